[rtl/core/lse_pkg.sv]
// ----------------------------------------------------------------------------
// lse_pkg: shared types for the LIFO stack engine
// Command and status codes, transfer payloads and the per-cell control bundle.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int WordW = 32;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_PEEK     = 2'd2,
    CMD_TRAVERSE = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    command_t                  command;
    logic signed [WordW-1:0]   data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0]   read_value;
    status_t                   status;
    logic                      last_of_run;
  } out_item_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,  // take the word above (cell 0: the pushed value)
    OP_POP  = 2'd2,  // take the word below
    OP_ROT  = 2'd3   // take the word below, the wrap cell takes the top word
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WordW-1:0]   push_word;
    logic signed [WordW-1:0]   wrap_word;
  } cell_ctrl_t;

endpackage

[rtl/core/lifo_stack_engine_unit.sv]
// ----------------------------------------------------------------------------
// lifo_stack_engine_unit: bounded LIFO stack of signed 32-bit words
// A row of DEPTH shift cells; cell 0 always holds the top of the stack.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying a command (push, pop, peek,
//           traverse) and a value used by push only.
//   out_* : valid/ready channel carrying read_value, status, last_of_run.
//   Push, pop and peek each yield one result, registered in the cycle after
//   the input transfer; a new command is taken every cycle while no traverse
//   runs and the output register is free or being drained in the same cycle.
//   Traverse yields one result per stored entry, top first, one per cycle
//   while the output is not stalled, by rotating the occupied cells up and
//   wrapping the top word into the lowest occupied cell; after entry_count
//   rotations the stack is back in its original order. It blocks new
//   commands until its last result is registered. Empty stack: single
//   result with empty status.
//   Reset (synchronous, rst_n low) empties the stack; cell contents are
//   not cleared since nothing below the fill count is ever read.
//   When the receiver stalls, the output register holds its result and
//   in_ready drops until that result is transferred.
// ----------------------------------------------------------------------------
module lifo_stack_engine_unit #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lse_pkg::in_item_t   in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output lse_pkg::out_item_t  out_payload
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TRAV = 2'b10
  } state_t;

  state_t              state_r,     state_nxt;
  logic [CW-1:0]       cnt_r,       cnt_nxt;    // entries stored
  logic [CW-1:0]       rem_r,       rem_nxt;    // traverse results still due
  logic                out_valid_r, out_valid_nxt;
  lse_pkg::out_item_t  out_r,       out_nxt;

  lse_pkg::cell_ctrl_t                ctrl;
  logic signed [lse_pkg::WordW-1:0]   cell_q [DEPTH];
  logic signed [lse_pkg::WordW-1:0]   top_word;

  logic slot_free;
  logic in_fire;
  logic is_full;
  logic is_empty;

  assign top_word  = cell_q[0];
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (cnt_r == CW'(DEPTH));
  assign is_empty  = (cnt_r == '0);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ctrl.op        = lse_pkg::OP_HOLD;
    ctrl.push_word = in_payload.data_value;
    ctrl.wrap_word = top_word;

    if (in_fire) begin
      out_valid_nxt       = 1'b1;
      out_nxt.read_value  = '0;
      out_nxt.status      = lse_pkg::ST_OK;
      out_nxt.last_of_run = 1'b1;
      unique case (in_payload.command)
        lse_pkg::CMD_PUSH: begin
          if (is_full) begin
            out_nxt.status = lse_pkg::ST_OVERFLOW;
          end else begin
            ctrl.op = lse_pkg::OP_PUSH;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        lse_pkg::CMD_POP: begin
          if (is_empty) begin
            out_nxt.status = lse_pkg::ST_EMPTY;
          end else begin
            ctrl.op            = lse_pkg::OP_POP;
            cnt_nxt            = cnt_r - CW'(1);
            out_nxt.read_value = top_word;
          end
        end
        lse_pkg::CMD_PEEK: begin
          if (is_empty) begin
            out_nxt.status = lse_pkg::ST_EMPTY;
          end else begin
            out_nxt.read_value = top_word;
          end
        end
        lse_pkg::CMD_TRAVERSE: begin
          if (is_empty) begin
            out_nxt.status = lse_pkg::ST_EMPTY;
          end else begin
            // first result goes out right away
            ctrl.op             = lse_pkg::OP_ROT;
            out_nxt.read_value  = top_word;
            out_nxt.last_of_run = (cnt_r == CW'(1));
            if (cnt_r != CW'(1)) begin
              state_nxt = S_TRAV;
              rem_nxt   = cnt_r - CW'(1);
            end
          end
        end
        default: begin
          out_nxt.status = lse_pkg::ST_EMPTY;
        end
      endcase
    end else if (state_r == S_TRAV && slot_free) begin
      ctrl.op             = lse_pkg::OP_ROT;
      out_valid_nxt       = 1'b1;
      out_nxt.read_value  = top_word;
      out_nxt.status      = lse_pkg::ST_OK;
      out_nxt.last_of_run = (rem_r == CW'(1));
      rem_nxt             = rem_r - CW'(1);
      if (rem_r == CW'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [lse_pkg::WordW-1:0] above_w;
    logic signed [lse_pkg::WordW-1:0] below_w;
    logic                             wrap_w;

    if (i == 0) begin : g_top
      assign above_w = ctrl.push_word;
    end else begin : g_mid
      assign above_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below_w = '0;
    end else begin : g_up
      assign below_w = cell_q[i+1];
    end

    // lowest occupied cell receives the top word during a rotate
    assign wrap_w = (cnt_r == CW'(i + 1));

    lse_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .is_wrap    (wrap_w),
      .from_above (above_w),
      .from_below (below_w),
      .word_q     (cell_q[i])
    );
  end

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_trav_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TRAV |-> rem_r != '0)
    else $error("traverse with nothing left to emit");

  a_trav_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TRAV |-> rem_r < cnt_r && $stable(cnt_r))
    else $error("fill count moved during traverse");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_payload.command == lse_pkg::CMD_PUSH && !is_full
    |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("push did not grow the stack");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_payload.command == lse_pkg::CMD_POP && !is_empty
    |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("pop did not shrink the stack");

endmodule

[rtl/core/lse_cell.sv]
// ----------------------------------------------------------------------------
// lse_cell: one stack slot
// Holds one word and shifts it toward the top or the bottom on command.
// ----------------------------------------------------------------------------
module lse_cell (
  input  logic                              clk,
  input  lse_pkg::cell_ctrl_t               ctrl,
  input  logic                              is_wrap,
  input  logic signed [lse_pkg::WordW-1:0]  from_above,
  input  logic signed [lse_pkg::WordW-1:0]  from_below,
  output logic signed [lse_pkg::WordW-1:0]  word_q
);

  logic signed [lse_pkg::WordW-1:0] word_r;
  logic signed [lse_pkg::WordW-1:0] word_nxt;

  always_comb begin
    unique case (ctrl.op)
      lse_pkg::OP_HOLD: word_nxt = word_r;
      lse_pkg::OP_PUSH: word_nxt = from_above;
      lse_pkg::OP_POP:  word_nxt = from_below;
      lse_pkg::OP_ROT:  word_nxt = is_wrap ? ctrl.wrap_word : from_below;
      default:          word_nxt = word_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule
